>>> design/bhbb_pkg.sv
`default_nettype none
package bhbb_pkg;

  localparam int NUM_BLOCKS = 4;
  localparam int BLOCK_LEN  = 256;

  localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int OFF_W  = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int DEPTH  = NUM_BLOCKS * BLOCK_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FILL_W = 7;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Ready blocks scaled to a percentage of the ring.
  function automatic logic [FILL_W-1:0] fill_pct(input logic [CNT_W-1:0] cnt);
    int scaled;
    scaled = (int'(cnt) * 100) / NUM_BLOCKS;
    return scaled[FILL_W-1:0];
  endfunction

  // Byte address of an offset within a block.
  function automatic logic [ADDR_W-1:0] store_addr(input logic [BLK_W-1:0] blk,
                                                  input logic [OFF_W-1:0] off);
    logic [ADDR_W+BLK_W-1:0] base;
    base = (ADDR_W+BLK_W)'(BLOCK_LEN) * (ADDR_W+BLK_W)'(blk);
    return base[ADDR_W-1:0] + ADDR_W'(off);
  endfunction

endpackage
`default_nettype wire

>>> design/block_handoff_byte_buffer.sv
// A result is registered in the store stage and shown once the skid is empty.
// Throughput: one item per cycle while in_stall_o is low; a skid stage absorbs
// a stall. The byte store has one port: at most one write or read per item.
// Reset (rst_ni low, asynchronous): all blocks free, both pointers and
// offsets at zero, result stages empty. Byte store contents are not cleared.
`default_nettype none
module block_handoff_byte_buffer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         cmd_i,
  input  wire logic [7:0]                   wr_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [7:0]                        rd_byte_o,
  output logic [1:0]                        status_o,
  output logic [bhbb_pkg::FILL_W-1:0]       fill_percent_o
);
  import bhbb_pkg::*;

  // Byte store: one synchronous port, registered read data.
  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Hand-off control state.
  logic [NUM_BLOCKS-1:0] block_ready_q, block_ready_d;
  logic [BLK_W-1:0]      wr_blk_q, wr_blk_d, rd_blk_q, rd_blk_d;
  logic [OFF_W-1:0]      wr_off_q, wr_off_d, rd_off_q, rd_off_d;
  logic [CNT_W-1:0]      ready_cnt_q, ready_cnt_d;

  // Result stage fed by the store, then a skid register.
  logic                  p_valid_q, p_valid_d;
  logic                  p_rd_q;
  status_e               p_status_q;
  logic [FILL_W-1:0]     p_fill_q;
  logic                  s_valid_q, s_valid_d;
  logic [7:0]            s_byte_q;
  status_e               s_status_q;
  logic [FILL_W-1:0]     s_fill_q;

  logic                  in_accept, out_take, do_wr, do_rd;
  status_e               status_d;
  logic [ADDR_W-1:0]     mem_addr;
  logic [7:0]            p_byte;

  // Stall the input only while the skid register holds an item.
  assign in_stall_o = s_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_o && !out_stall_i;

  // Decide the item against the current pointers and advance them.
  always_comb begin
    block_ready_d = block_ready_q;
    wr_blk_d      = wr_blk_q;
    rd_blk_d      = rd_blk_q;
    wr_off_d      = wr_off_q;
    rd_off_d      = rd_off_q;
    ready_cnt_d   = ready_cnt_q;
    do_wr         = 1'b0;
    do_rd         = 1'b0;
    status_d      = ST_OK;
    mem_addr      = store_addr(rd_blk_q, rd_off_q);
    if (cmd_e'(cmd_i) == CMD_WRITE) begin
      mem_addr = store_addr(wr_blk_q, wr_off_q);
      if (block_ready_q[wr_blk_q]) begin
        // Drop the byte: the writer's block has not been drained yet.
        status_d = ST_FULL;
      end else begin
        do_wr = in_accept;
        if (wr_off_q == OFF_W'(BLOCK_LEN - 1)) begin
          // Block complete: hand it to the reader and move on.
          wr_off_d                = '0;
          block_ready_d[wr_blk_q] = 1'b1;
          ready_cnt_d             = ready_cnt_q + 1'b1;
          wr_blk_d = (wr_blk_q == BLK_W'(NUM_BLOCKS - 1)) ? '0 : wr_blk_q + 1'b1;
        end else begin
          wr_off_d = wr_off_q + 1'b1;
        end
      end
    end else begin
      if (!block_ready_q[rd_blk_q]) begin
        status_d = ST_EMPTY;
      end else begin
        do_rd = in_accept;
        if (rd_off_q == OFF_W'(BLOCK_LEN - 1)) begin
          // Last byte taken: free the block for the writer.
          rd_off_d                = '0;
          block_ready_d[rd_blk_q] = 1'b0;
          ready_cnt_d             = ready_cnt_q - 1'b1;
          rd_blk_d = (rd_blk_q == BLK_W'(NUM_BLOCKS - 1)) ? '0 : rd_blk_q + 1'b1;
        end else begin
          rd_off_d = rd_off_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_ready_q <= '0;
      wr_blk_q      <= '0;
      rd_blk_q      <= '0;
      wr_off_q      <= '0;
      rd_off_q      <= '0;
      ready_cnt_q   <= '0;
    end else if (in_accept) begin
      block_ready_q <= block_ready_d;
      wr_blk_q      <= wr_blk_d;
      rd_blk_q      <= rd_blk_d;
      wr_off_q      <= wr_off_d;
      rd_off_q      <= rd_off_d;
      ready_cnt_q   <= ready_cnt_d;
    end
  end

  // Store port. The reader only touches completed blocks, so a read never
  // meets a write to the same byte.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[mem_addr] <= wr_byte_i;
    end
    if (do_rd) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  assign p_byte = p_rd_q ? rdata_q : 8'd0;

  // Show the skid item first; otherwise show the item leaving the store.
  assign out_valid_o    = s_valid_q || p_valid_q;
  assign rd_byte_o      = s_valid_q ? s_byte_q : p_byte;
  assign status_o       = s_valid_q ? s_status_q : p_status_q;
  assign fill_percent_o = s_valid_q ? s_fill_q : p_fill_q;

  always_comb begin
    s_valid_d = s_valid_q;
    p_valid_d = p_valid_q;
    if (s_valid_q) begin
      // Input is stalled, so hold the store stage.
      if (out_take) begin
        s_valid_d = 1'b0;
      end
    end else begin
      // Store stage is shown: it leaves now, or parks in the skid register.
      s_valid_d = p_valid_q && !out_take;
      p_valid_d = in_accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      p_rd_q     <= do_rd;
      p_status_q <= status_d;
      p_fill_q   <= fill_pct(ready_cnt_d);
    end
    if (!s_valid_q && p_valid_q && !out_take) begin
      s_byte_q   <= p_byte;
      s_status_q <= p_status_q;
      s_fill_q   <= p_fill_q;
    end
  end

  // The count of ready blocks tracks the ready flags.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_cnt_q == CNT_W'($countones(block_ready_q)))
    else $error("ready count differs from ready flags");

  // With both pointers on one block, the ring is either empty or full.
  a_ring_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_blk_q == rd_blk_q) |->
      (ready_cnt_q == '0 || ready_cnt_q == CNT_W'(NUM_BLOCKS)))
    else $error("pointers coincide on a partly filled ring");

  // An accepted item always reaches the store stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> p_valid_q)
    else $error("accepted item lost");

  // The skid register fills only from a stalled, shown store stage.
  a_skid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_valid_q) |-> $past(p_valid_q && out_stall_i))
    else $error("skid filled without a stalled result");

endmodule
`default_nettype wire
